[hdl/clock_and_countdown_timer_unit_assert.svh]
// ----------------------------------------------------------------------------
// Clock and countdown timer assertion macros
// Shorthand for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CLOCK_AND_COUNTDOWN_TIMER_UNIT_ASSERT_SVH
`define CLOCK_AND_COUNTDOWN_TIMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cct_pkg.sv]
// ----------------------------------------------------------------------------
// Clock and countdown timer package
// Item types, state record, register indexes and key masks.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int ACC_W = 13;

    localparam logic [ACC_W-1:0] ACC_MAX = 13'd8191;

    localparam logic [5:0] MIN_SEC_MAX = 6'd59;
    localparam logic [4:0] HOUR_MAX    = 5'd23;

    localparam logic [7:0] KEY_CLK_S = 8'h01;
    localparam logic [7:0] KEY_CLK_M = 8'h02;
    localparam logic [7:0] KEY_CLK_H = 8'h04;
    localparam logic [7:0] KEY_TMR_S = 8'h10;
    localparam logic [7:0] KEY_TMR_M = 8'h20;
    localparam logic [7:0] KEY_TMR_H = 8'h40;
    localparam logic [7:0] KEY_START = 8'h80;

    localparam logic [1:0] CFG_TICK_MS       = 2'd0;
    localparam logic [1:0] CFG_MS_PER_SECOND = 2'd1;
    localparam logic [1:0] CFG_REPEAT_MS     = 2'd2;

    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_ALARM   = 2'd2;

    typedef enum logic [2:0] {
        ST_STOPPED = 3'b001,
        ST_RUNNING = 3'b010,
        ST_ALARM   = 3'b100
    } run_state_t;

    typedef struct packed {
        logic       tick;
        logic [7:0] buttons;
    } cct_in_t;

    typedef struct packed {
        logic [4:0] clock_hours;
        logic [5:0] clock_minutes;
        logic [5:0] clock_seconds;
        logic [4:0] timer_hours;
        logic [5:0] timer_minutes;
        logic [5:0] timer_seconds;
        logic [1:0] mode;
        logic       buzzer;
        logic       alarm_lamp;
    } cct_out_t;

    typedef struct packed {
        logic [9:0]  tick_ms;
        logic [11:0] ms_per_second;
        logic [11:0] repeat_ms;
    } cct_cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0] ms_acc;
        logic [ACC_W-1:0] rep_acc;
        logic [7:0]       repeat_key;
        logic [7:0]       held_keys;
        logic [4:0]       clock_h;
        logic [5:0]       clock_m;
        logic [5:0]       clock_s;
        logic [4:0]       down_h;
        logic [5:0]       down_m;
        logic [5:0]       down_s;
        run_state_t       run_state;
        logic             buzzer;
        logic             lamp;
    } cct_state_t;

endpackage

[hdl/clock_and_countdown_timer_unit.sv]
// ----------------------------------------------------------------------------
// Clock and countdown timer unit
// Digital hh:mm:ss clock with a countdown timer, alarm and key handling.
// ----------------------------------------------------------------------------
// Each input item carries a tick flag and a sample of eight key levels; each
// accepted item yields exactly one result item with the clock, the timer, the
// timer mode, the buzzer level and the alarm lamp after that item.
// Items move on a valid/stall handshake: an item is taken at a clock edge
// where valid is high and stall is low, on the input and the result side.
// An accepted item waits in the input register; the step logic then
// updates the state register, whose contents form the result, which is
// valid from that update; one item per cycle is sustained without stalls.
// The input register takes a new item while a result waits, so a stall on
// the result side reaches the input side only once the input register is
// full; a stalled result holds its value.
// Configuration registers tick_ms, ms_per_second and repeat_ms: the user must
// write them via cfg_we, cfg_index and cfg_data while idle; not enforced.
// Reset clears the clock, the timer, the accumulators and the key history,
// stops the timer and restores the register defaults 33, 1000 and 300.
// ----------------------------------------------------------------------------
module clock_and_countdown_timer_unit
    import cct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  cct_in_t     item,
    output logic        result_valid,
    input  logic        result_stall,
    output cct_out_t    result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    logic       item_vld_reg;
    cct_in_t    item_reg;
    logic       result_vld_reg;
    cct_state_t state_reg;
    cct_state_t state_next;
    cct_cfg_t   cfg_reg;
    logic       advance;

    assign advance    = !result_vld_reg || !result_stall;
    assign item_stall = item_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_ms       <= 10'd33;
            cfg_reg.ms_per_second <= 12'd1000;
            cfg_reg.repeat_ms     <= 12'd300;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TICK_MS:       cfg_reg.tick_ms       <= cfg_data[9:0];
                CFG_MS_PER_SECOND: cfg_reg.ms_per_second <= cfg_data;
                CFG_REPEAT_MS:     cfg_reg.repeat_ms     <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_vld_reg <= 1'b0;
            state_reg      <= '{ms_acc: '0, rep_acc: '0, repeat_key: '0, held_keys: '0,
                                clock_h: '0, clock_m: '0, clock_s: '0,
                                down_h: '0, down_m: '0, down_s: '0,
                                run_state: ST_STOPPED, buzzer: 1'b0, lamp: 1'b0};
        end
        else if (advance)
        begin
            result_vld_reg <= item_vld_reg;
            if (item_vld_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    cct_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state_next (state_next)
    );

    always_comb
    begin
        result.clock_hours   = state_reg.clock_h;
        result.clock_minutes = state_reg.clock_m;
        result.clock_seconds = state_reg.clock_s;
        result.timer_hours   = state_reg.down_h;
        result.timer_minutes = state_reg.down_m;
        result.timer_seconds = state_reg.down_s;
        result.buzzer        = state_reg.buzzer;
        result.alarm_lamp    = state_reg.lamp;
        unique case (state_reg.run_state)
            ST_RUNNING: result.mode = MODE_RUNNING;
            ST_ALARM:   result.mode = MODE_ALARM;
            default:    result.mode = MODE_STOPPED;
        endcase
    end

    assign result_valid = result_vld_reg;

endmodule

[hdl/cct_step.sv]
// ----------------------------------------------------------------------------
// Clock and countdown timer step logic
// Computes the state left by one item: ticks, one second, one key press and
// auto-repeat, in that order.
// ----------------------------------------------------------------------------
module cct_step
    import cct_pkg::*;
(
    input  cct_state_t state,
    input  cct_cfg_t   cfg,
    input  cct_in_t    item,
    output cct_state_t state_next
);

    function automatic cct_state_t clk_hour_inc(cct_state_t st);
        cct_state_t r;
        r = st;
        r.clock_h = (st.clock_h >= HOUR_MAX) ? 5'd0 : st.clock_h + 5'd1;
        return r;
    endfunction

    function automatic cct_state_t clk_min_inc(cct_state_t st);
        cct_state_t r;
        r = st;
        if (st.clock_m >= MIN_SEC_MAX)
        begin
            r.clock_m = 6'd0;
            r = clk_hour_inc(r);
        end
        else
        begin
            r.clock_m = st.clock_m + 6'd1;
        end
        return r;
    endfunction

    function automatic cct_state_t clk_sec_inc(cct_state_t st);
        cct_state_t r;
        r = st;
        if (st.clock_s >= MIN_SEC_MAX)
        begin
            r.clock_s = 6'd0;
            r = clk_min_inc(r);
        end
        else
        begin
            r.clock_s = st.clock_s + 6'd1;
        end
        return r;
    endfunction

    function automatic cct_state_t key_inc(cct_state_t st, logic [7:0] key);
        cct_state_t r;
        r = st;
        case (key)
            KEY_CLK_H: r = clk_hour_inc(st);
            KEY_CLK_M: r = clk_min_inc(st);
            KEY_CLK_S: r = clk_sec_inc(st);
            KEY_TMR_H: r.down_h = (st.down_h >= HOUR_MAX) ? 5'd0 : st.down_h + 5'd1;
            KEY_TMR_M: r.down_m = (st.down_m >= MIN_SEC_MAX) ? 6'd0 : st.down_m + 6'd1;
            KEY_TMR_S: r.down_s = (st.down_s >= MIN_SEC_MAX) ? 6'd0 : st.down_s + 6'd1;
            default:   r = st;
        endcase
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] acc_add(logic [ACC_W-1:0] a, logic [9:0] b);
        logic [ACC_W:0] sum;
        sum = {1'b0, a} + {4'd0, b};
        return (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_W-1:0];
    endfunction

    always_comb
    begin
        cct_state_t st;
        logic [7:0] fresh;
        logic [7:0] press;
        logic       running;

        st = state;

        if (item.tick)
        begin
            st.ms_acc = acc_add(st.ms_acc, cfg.tick_ms);
            if (st.repeat_key != 8'd0)
            begin
                st.rep_acc = acc_add(st.rep_acc, cfg.tick_ms);
            end
        end

        running = (st.run_state == ST_RUNNING);
        if (st.ms_acc >= {1'b0, cfg.ms_per_second})
        begin
            st.ms_acc = st.ms_acc - {1'b0, cfg.ms_per_second};
            st.buzzer = st.buzzer ^ running;
            st = clk_sec_inc(st);
            if (running)
            begin
                if (st.down_s == 6'd0)
                begin
                    st.down_s = MIN_SEC_MAX;
                    if (st.down_m == 6'd0)
                    begin
                        st.down_m = MIN_SEC_MAX;
                        st.down_h = (st.down_h == 5'd0) ? HOUR_MAX : st.down_h - 5'd1;
                    end
                    else
                    begin
                        st.down_m = st.down_m - 6'd1;
                    end
                end
                else
                begin
                    st.down_s = st.down_s - 6'd1;
                end
                if (st.down_s == 6'd0 && st.down_m == 6'd0 && st.down_h == 5'd0)
                begin
                    st.run_state = ST_ALARM;
                    st.lamp      = 1'b1;
                    st.buzzer    = 1'b1;
                end
            end
        end

        // Only the highest-priority new key acts in one item.
        fresh = item.buttons & ~st.held_keys;
        if ((fresh & KEY_CLK_H) != 8'd0)
            press = KEY_CLK_H;
        else if ((fresh & KEY_CLK_M) != 8'd0)
            press = KEY_CLK_M;
        else if ((fresh & KEY_CLK_S) != 8'd0)
            press = KEY_CLK_S;
        else if ((fresh & KEY_TMR_H) != 8'd0)
            press = KEY_TMR_H;
        else if ((fresh & KEY_TMR_M) != 8'd0)
            press = KEY_TMR_M;
        else if ((fresh & KEY_TMR_S) != 8'd0)
            press = KEY_TMR_S;
        else if ((fresh & KEY_START) != 8'd0)
            press = KEY_START;
        else
            press = 8'd0;

        st.held_keys = st.held_keys | press;
        if (press == KEY_START)
        begin
            unique case (st.run_state)
                ST_RUNNING:
                begin
                    st.run_state = ST_STOPPED;
                    st.buzzer    = 1'b0;
                    st.down_h    = 5'd0;
                    st.down_m    = 6'd0;
                    st.down_s    = 6'd0;
                end
                ST_ALARM:
                begin
                    st.run_state = ST_STOPPED;
                    st.buzzer    = 1'b0;
                    st.lamp      = 1'b0;
                end
                default:
                begin
                    st.run_state = ST_RUNNING;
                end
            endcase
        end
        else if (press != 8'd0)
        begin
            st = key_inc(st, press);
            st.repeat_key = press;
        end

        st.held_keys = st.held_keys & item.buttons;

        if ((st.repeat_key & ~st.held_keys) != 8'd0)
        begin
            st.repeat_key = 8'd0;
            st.rep_acc    = '0;
        end
        else if (st.rep_acc >= {1'b0, cfg.repeat_ms})
        begin
            st.rep_acc = st.rep_acc - {1'b0, cfg.repeat_ms};
            st = key_inc(st, st.repeat_key);
        end

        state_next = st;
    end

endmodule

[hdl/cct_checker.sv]
// ----------------------------------------------------------------------------
// Clock and countdown timer checker
// Port-level checks on result items, bound to the top level.
// ----------------------------------------------------------------------------
`include "clock_and_countdown_timer_unit_assert.svh"

module cct_checker
    import cct_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     item_valid,
    input logic     item_stall,
    input cct_in_t  item,
    input logic     result_valid,
    input logic     result_stall,
    input cct_out_t result
);

    logic item_take;

    assign item_take = item_valid && !item_stall && (item.buttons == item.buttons);

    `CCT_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result item changed")

    `CCT_ASSERT_IMP(a_field_range, result_valid, result.clock_hours <= HOUR_MAX && result.clock_minutes <= MIN_SEC_MAX && result.clock_seconds <= MIN_SEC_MAX && result.timer_hours <= HOUR_MAX && result.timer_minutes <= MIN_SEC_MAX && result.timer_seconds <= MIN_SEC_MAX, "result field out of range")

    `CCT_ASSERT_IMP(a_lamp_alarm, result_valid, result.alarm_lamp == (result.mode == MODE_ALARM), "alarm lamp disagrees with mode")

    `CCT_ASSERT_IMP(a_buzzer_mode, result_valid && (result.mode == MODE_STOPPED || result.mode == MODE_ALARM), result.buzzer == (result.mode == MODE_ALARM), "buzzer level wrong for mode")

    `CCT_ASSERT_NXT(a_item_to_result, item_take && !result_valid, ##1 result_valid, "accepted item gave no result")

endmodule

bind clock_and_countdown_timer_unit cct_checker u_cct_checker (.*);

[tb/sv/cct_readout_checker.sv]
// ----------------------------------------------------------------------------
// Clock and countdown timer readout checker
// Watches both item channels and the register port, keeps its own model of
// the clock, the countdown timer and the key handling, and compares every
// result item field by field with the readout it predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cct_readout_checker
    import cct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  cct_in_t     item,
    input  logic        result_valid,
    input  logic        result_stall,
    input  cct_out_t    result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output int          failures,
    output int          pending,
    output int          checked,
    output int          alarms
);

    localparam logic [7:0] KEY_RANK [7] = '{KEY_CLK_H, KEY_CLK_M, KEY_CLK_S,
                                            KEY_TMR_H, KEY_TMR_M, KEY_TMR_S,
                                            KEY_START};

    localparam cct_cfg_t RESET_REGS = '{tick_ms: 10'd33, ms_per_second: 12'd1000,
                                        repeat_ms: 12'd300};

    cct_cfg_t    regs;
    int unsigned ms_sum;
    int unsigned rep_sum;
    logic [7:0]  rep_key;
    logic [7:0]  keys_down;
    int unsigned hh, mm, ss;
    int unsigned th, tm, ts;
    logic [1:0]  run_mode;
    logic        buzz;
    logic        lamp;

    cct_out_t    expected_readouts [$];

    function automatic int unsigned saturating_sum(int unsigned a, int unsigned b);
        return (a + b > ACC_MAX) ? int'(ACC_MAX) : a + b;
    endfunction

    function automatic void carry_clock();
        if (ss > MIN_SEC_MAX)
        begin
            ss = 0;
            mm++;
        end
        if (mm > MIN_SEC_MAX)
        begin
            mm = 0;
            hh++;
        end
        if (hh > HOUR_MAX)
            hh = 0;
    endfunction

    function automatic void bump_field(logic [7:0] key);
        case (key)
            KEY_CLK_H:
            begin
                hh++;
                carry_clock();
            end
            KEY_CLK_M:
            begin
                mm++;
                carry_clock();
            end
            KEY_CLK_S:
            begin
                ss++;
                carry_clock();
            end
            KEY_TMR_H: th = (th >= HOUR_MAX) ? 0 : th + 1;
            KEY_TMR_M: tm = (tm >= MIN_SEC_MAX) ? 0 : tm + 1;
            KEY_TMR_S: ts = (ts >= MIN_SEC_MAX) ? 0 : ts + 1;
            default: ;
        endcase
    endfunction

    function automatic cct_out_t advance_timekeeper(cct_in_t it);
        logic [7:0] fresh;
        logic       running;
        cct_out_t   r;
        if (it.tick)
        begin
            ms_sum = saturating_sum(ms_sum, regs.tick_ms);
            if (rep_key != '0)
                rep_sum = saturating_sum(rep_sum, regs.tick_ms);
        end
        if (ms_sum >= regs.ms_per_second)
        begin
            ms_sum -= regs.ms_per_second;
            running = (run_mode == MODE_RUNNING);
            if (running)
                buzz = ~buzz;
            ss++;
            carry_clock();
            if (running)
            begin
                if (ts == 0)
                begin
                    ts = MIN_SEC_MAX;
                    if (tm == 0)
                    begin
                        tm = MIN_SEC_MAX;
                        th = (th == 0) ? HOUR_MAX : th - 1;
                    end
                    else
                        tm--;
                end
                else
                    ts--;
                if (ts == 0 && tm == 0 && th == 0)
                begin
                    run_mode = MODE_ALARM;
                    lamp = 1'b1;
                    buzz = 1'b1;
                    alarms++;
                end
            end
        end
        fresh = it.buttons & ~keys_down;
        for (int i = 0; i < 7; i++)
        begin
            if ((fresh & KEY_RANK[i]) != '0)
            begin
                keys_down |= KEY_RANK[i];
                if (KEY_RANK[i] == KEY_START)
                begin
                    case (run_mode)
                        MODE_RUNNING:
                        begin
                            run_mode = MODE_STOPPED;
                            buzz = 1'b0;
                            th = 0;
                            tm = 0;
                            ts = 0;
                        end
                        MODE_ALARM:
                        begin
                            run_mode = MODE_STOPPED;
                            buzz = 1'b0;
                            lamp = 1'b0;
                        end
                        default: run_mode = MODE_RUNNING;
                    endcase
                end
                else
                begin
                    bump_field(KEY_RANK[i]);
                    rep_key = KEY_RANK[i];
                end
                break;
            end
        end
        keys_down &= it.buttons;
        if ((rep_key & ~keys_down) != '0)
        begin
            rep_key = '0;
            rep_sum = 0;
        end
        else if (rep_sum >= regs.repeat_ms)
        begin
            rep_sum -= regs.repeat_ms;
            bump_field(rep_key);
        end
        r.clock_hours   = 5'(hh);
        r.clock_minutes = 6'(mm);
        r.clock_seconds = 6'(ss);
        r.timer_hours   = 5'(th);
        r.timer_minutes = 6'(tm);
        r.timer_seconds = 6'(ts);
        r.mode          = run_mode;
        r.buzzer        = buzz;
        r.alarm_lamp    = lamp;
        return r;
    endfunction

    task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cct_out_t want;
        if (!rst_n)
        begin
            regs      = RESET_REGS;
            ms_sum    = 0;
            rep_sum   = 0;
            rep_key   = '0;
            keys_down = '0;
            hh = 0;
            mm = 0;
            ss = 0;
            th = 0;
            tm = 0;
            ts = 0;
            run_mode  = MODE_STOPPED;
            buzz      = 1'b0;
            lamp      = 1'b0;
            expected_readouts.delete();
            pending   = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_readouts.size() == 0)
                begin
                    $error("result item arrived with no expectation waiting");
                    failures++;
                end
                else
                begin
                    want = expected_readouts.pop_front();
                    report_field("clock_hours", want.clock_hours, result.clock_hours);
                    report_field("clock_minutes", want.clock_minutes, result.clock_minutes);
                    report_field("clock_seconds", want.clock_seconds, result.clock_seconds);
                    report_field("timer_hours", want.timer_hours, result.timer_hours);
                    report_field("timer_minutes", want.timer_minutes, result.timer_minutes);
                    report_field("timer_seconds", want.timer_seconds, result.timer_seconds);
                    report_field("mode", want.mode, result.mode);
                    report_field("buzzer", want.buzzer, result.buzzer);
                    report_field("alarm_lamp", want.alarm_lamp, result.alarm_lamp);
                    checked++;
                end
            end
            if (item_valid && !item_stall)
                expected_readouts.push_back(advance_timekeeper(item));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TICK_MS:       regs.tick_ms       = cfg_data[9:0];
                    CFG_MS_PER_SECOND: regs.ms_per_second = cfg_data;
                    CFG_REPEAT_MS:     regs.repeat_ms     = cfg_data;
                    default: ;
                endcase
            end
            pending = expected_readouts.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Clock and countdown timer testbench
// Drives key samples and ticks through the unit under eight register
// settings, with random gaps and stalls on both channels and long result
// hold-offs, while a checker module predicts and compares every readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import cct_pkg::*;

    localparam logic [7:0] KEY_SPARE = 8'h08;
    localparam logic [7:0] ALL_KEYS  = 8'hFF;
    localparam logic [7:0] NO_KEYS   = 8'h00;
    localparam logic [7:0] KEY_SET [7] = '{KEY_CLK_S, KEY_CLK_M, KEY_CLK_H,
                                           KEY_TMR_S, KEY_TMR_M, KEY_TMR_H,
                                           KEY_START};

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    cct_in_t     item;
    logic        result_valid;
    logic        result_stall;
    cct_out_t    result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    int failures;
    int pending;
    int checked;
    int alarms;
    int items_sent = 0;
    int send_calm = 0;
    int recv_calm = 0;
    int recv_count = 0;

    clock_and_countdown_timer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    cct_readout_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .pending      (pending),
        .checked      (checked),
        .alarms       (alarms)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            calm = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic cct_in_t sample_of(logic t, logic [7:0] keys);
        cct_in_t s;
        s.tick    = t;
        s.buttons = keys;
        return s;
    endfunction

    function automatic logic tick_coin();
        return ($urandom_range(0, 3) != 0);
    endfunction

    task automatic offer(input cct_in_t it);
        int gap;
        gap = pick_gap(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_settings(input int t, input int m, input int r);
        settle();
        write_reg(CFG_TICK_MS, 12'(t));
        write_reg(CFG_MS_PER_SECOND, 12'(m));
        write_reg(CFG_REPEAT_MS, 12'(r));
    endtask

    task automatic key_session(input int quota);
        int         first;
        int         n;
        logic [7:0] key;
        first = items_sent;
        while (items_sent - first < quota)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    n = $urandom_range(1, 8);
                    repeat (n) offer(sample_of(tick_coin(), NO_KEYS));
                end
                3, 4, 5:
                begin
                    key = KEY_SET[$urandom_range(0, 6)];
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 90)
                                                    : $urandom_range(1, 12);
                    repeat (n) offer(sample_of(tick_coin(), key));
                    offer(sample_of(tick_coin(), NO_KEYS));
                end
                6:
                begin
                    offer(sample_of(tick_coin(), KEY_START));
                    offer(sample_of(tick_coin(), NO_KEYS));
                end
                7:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) offer(sample_of(1'($urandom_range(0, 1)),
                                               8'($urandom_range(0, 255))));
                end
                8:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                    begin
                        key = ($urandom_range(0, 3) == 0) ? KEY_SET[$urandom_range(3, 5)]
                                                          : KEY_TMR_S;
                        offer(sample_of(tick_coin(), key));
                        offer(sample_of(tick_coin(), NO_KEYS));
                    end
                    offer(sample_of(tick_coin(), KEY_START));
                    n = $urandom_range(2, 20);
                    repeat (n) offer(sample_of(tick_coin(), NO_KEYS));
                end
                default:
                begin
                    key = KEY_SET[$urandom_range(0, 5)];
                    n = $urandom_range(2, 15);
                    repeat (n)
                        offer(sample_of(tick_coin(), key | 8'($urandom_range(0, 255)
                                                             & $urandom_range(0, 255))));
                    offer(sample_of(tick_coin(), NO_KEYS));
                end
            endcase
        end
    endtask

    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (recv_count == 200 || recv_count == 520 || recv_count == 900)
                n = 160;
            else
                n = pick_gap(recv_calm);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            recv_count++;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_TICK_MS;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        offer(sample_of(1'b0, NO_KEYS));
        repeat (7) offer(sample_of(1'b1, ALL_KEYS));
        offer(sample_of(1'b0, NO_KEYS));
        offer(sample_of(1'b1, KEY_SPARE));
        offer(sample_of(1'b0, KEY_START));
        offer(sample_of(1'b0, NO_KEYS));
        offer(sample_of(1'b0, KEY_START));
        offer(sample_of(1'b0, NO_KEYS));
        key_session(130);

        apply_settings(999, 1, 1);
        offer(sample_of(1'b0, KEY_START));
        offer(sample_of(1'b1, NO_KEYS));
        offer(sample_of(1'b0, KEY_START));
        offer(sample_of(1'b0, NO_KEYS));
        offer(sample_of(1'b0, KEY_TMR_S));
        offer(sample_of(1'b0, NO_KEYS));
        offer(sample_of(1'b0, KEY_START));
        offer(sample_of(1'b0, NO_KEYS));
        offer(sample_of(1'b1, NO_KEYS));
        offer(sample_of(1'b0, KEY_START));
        offer(sample_of(1'b0, NO_KEYS));
        key_session(140);

        apply_settings(1, 4095, 4095);
        key_session(120);
        apply_settings(250, 1000, 500);
        key_session(140);
        apply_settings(0, 0, 0);
        key_session(130);
        apply_settings(1023, 4095, 1);
        key_session(130);
        apply_settings(100, 200, 4095);
        key_session(140);
        apply_settings(33, 1000, 300);
        key_session(150);

        settle();
        $display("Sent %0d items under eight register settings; %0d readouts compared.",
                 items_sent, checked);
        $display("Predicted alarm entries: %0d; field mismatches: %0d.", alarms, failures);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
